// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the three-class strict priority event queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int CLS_W       = 2;
  localparam int ID_PORT_W   = 16;
  localparam int VALUE_W     = 32;
  localparam int LVL_OUT_W   = 5;

  // request function codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // event classes, highest priority first
  localparam logic [CLS_W-1:0] CLS_HIGH   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LOW    = 2'd2;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    status_t                status;
    logic                   served;
    logic [CLS_W-1:0]       served_class;
    logic [LVL_OUT_W-1:0]   level_high;
    logic [LVL_OUT_W-1:0]   level_medium;
    logic [LVL_OUT_W-1:0]   level_low;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== rtl/spq_in_if.sv =====
// ----------------------------------------------------------------------------
// spq_in_if
// Request channel: enqueue or dequeue request with event payload.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [spq_pkg::CLS_W-1:0]            priority_req;
  logic [spq_pkg::ID_PORT_W-1:0]        device_id;
  logic                                 has_sensor;
  logic [spq_pkg::ID_PORT_W-1:0]        sensor_id;
  logic [spq_pkg::VALUE_W-1:0]          event_value;

  modport source (
    output valid, func, priority_req, device_id, has_sensor, sensor_id, event_value,
    input  ready
  );

  modport sink (
    input  valid, func, priority_req, device_id, has_sensor, sensor_id, event_value,
    output ready
  );
endinterface

// ===== rtl/spq_out_if.sv =====
// ----------------------------------------------------------------------------
// spq_out_if
// Result channel: status, served event and fill levels.
// ----------------------------------------------------------------------------
interface spq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic [spq_pkg::CLS_W-1:0]            served_class;
  logic [spq_pkg::ID_PORT_W-1:0]        served_device;
  logic                                 served_has_sensor;
  logic [spq_pkg::ID_PORT_W-1:0]        served_sensor;
  logic [spq_pkg::VALUE_W-1:0]          served_value;
  logic [spq_pkg::LVL_OUT_W-1:0]        level_high;
  logic [spq_pkg::LVL_OUT_W-1:0]        level_medium;
  logic [spq_pkg::LVL_OUT_W-1:0]        level_low;

  modport source (
    output valid, status, served_class, served_device, served_has_sensor,
           served_sensor, served_value, level_high, level_medium, level_low,
    input  ready
  );

  modport sink (
    input  valid, status, served_class, served_device, served_has_sensor,
           served_sensor, served_value, level_high, level_medium, level_low,
    output ready
  );
endinterface

// ===== rtl/spq_mem.sv =====
// ----------------------------------------------------------------------------
// spq_mem
// Single-port event store with registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module spq_mem #(
  parameter int WIDTH  = 65,
  parameter int DEPTH  = 48,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wr_data,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Per-class head, tail and fill level; class selection and store addressing.
// ----------------------------------------------------------------------------
module spq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ADDR_W      = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          func,
  input  logic [spq_pkg::CLS_W-1:0]     cls_raw,
  output spq_pkg::result_t              res,
  output spq_pkg::mem_ctl_t             mem_ctl,
  output logic [ADDR_W-1:0]             mem_addr
);

  localparam int NC        = spq_pkg::NUM_CLASSES;
  localparam int CLS_W     = spq_pkg::CLS_W;
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_OUT_W = spq_pkg::LVL_OUT_W;

  logic [LVL_W-1:0] lvl_r    [NC];
  logic [LVL_W-1:0] lvl_nxt  [NC];
  logic [PTR_W-1:0] head_r   [NC];
  logic [PTR_W-1:0] head_nxt [NC];
  logic [PTR_W-1:0] tail_r   [NC];
  logic [PTR_W-1:0] tail_nxt [NC];

  logic [CLS_W-1:0] cls;
  logic [CLS_W-1:0] sel_cls;
  logic [CLS_W-1:0] addr_cls;
  logic [NC-1:0]    full;
  logic             sel_hit;
  logic             enq;
  logic             enq_ok;
  logic             deq_ok;
  logic [PTR_W-1:0] ptr;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    // class three is served as low
    cls = (cls_raw > spq_pkg::CLS_LOW) ? spq_pkg::CLS_LOW : cls_raw;
    enq = (func == spq_pkg::FUNC_ENQ);

    // lowest non-empty class index wins
    sel_hit = 1'b0;
    sel_cls = spq_pkg::CLS_LOW;
    for (int c = NC - 1; c >= 0; c--) begin
      full[c] = (lvl_r[c] == LVL_W'(QUEUE_DEPTH));
      if (lvl_r[c] != '0) begin
        sel_hit = 1'b1;
        sel_cls = CLS_W'(c);
      end
    end

    enq_ok   = enq && !full[cls];
    deq_ok   = !enq && sel_hit;
    addr_cls = enq ? cls : sel_cls;

    ptr = '0;
    for (int c = 0; c < NC; c++) begin
      if (addr_cls == CLS_W'(c)) begin
        ptr = enq ? tail_r[c] : head_r[c];
      end
      lvl_nxt[c]  = lvl_r[c];
      head_nxt[c] = head_r[c];
      tail_nxt[c] = tail_r[c];
      if (enq_ok && cls == CLS_W'(c)) begin
        lvl_nxt[c]  = lvl_r[c] + LVL_W'(1);
        tail_nxt[c] = next_ptr(tail_r[c]);
      end
      if (deq_ok && sel_cls == CLS_W'(c)) begin
        lvl_nxt[c] = lvl_r[c] - LVL_W'(1);
        // last event out: both pointers go back to the start of the ring
        if (lvl_r[c] == LVL_W'(1)) begin
          head_nxt[c] = '0;
          tail_nxt[c] = '0;
        end else begin
          head_nxt[c] = next_ptr(head_r[c]);
        end
      end
    end

    mem_addr = ADDR_W'(addr_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);

    res.status       = enq ? (enq_ok ? spq_pkg::ST_ENQ : spq_pkg::ST_FULL)
                           : (sel_hit ? spq_pkg::ST_DEQ : spq_pkg::ST_EMPTY);
    res.served       = deq_ok;
    res.served_class = sel_cls;
    res.level_high   = LVL_OUT_W'(lvl_nxt[spq_pkg::CLS_HIGH]);
    res.level_medium = LVL_OUT_W'(lvl_nxt[spq_pkg::CLS_MEDIUM]);
    res.level_low    = LVL_OUT_W'(lvl_nxt[spq_pkg::CLS_LOW]);

    mem_ctl.wr_en = adv && enq_ok;
    mem_ctl.rd_en = adv && deq_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NC; c++) begin
        lvl_r[c]  <= '0;
        head_r[c] <= '0;
        tail_r[c] <= '0;
      end
    end else if (adv) begin
      for (int c = 0; c < NC; c++) begin
        lvl_r[c]  <= lvl_nxt[c];
        head_r[c] <= head_nxt[c];
        tail_r[c] <= tail_nxt[c];
      end
    end
  end

endmodule

// ===== rtl/strict_priority_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// strict_priority_event_queue_core
// Three-class strict priority event queue with shared event store.
// ----------------------------------------------------------------------------
// a request waits in the input register, and its result in the result register
// throughput: one request per cycle unless results stall; at most one store access (read or write) each
// the single store port and the per-class pointer update set the rate
// reset clears pointers, fill levels and handshake state
// store contents are not cleared; a slot is only read after it was written
module strict_priority_event_queue_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  spq_in_if.sink        in_chan,
  spq_out_if.source     out_chan
);

  localparam int VALUE_W   = spq_pkg::VALUE_W;
  localparam int ID_PORT_W = spq_pkg::ID_PORT_W;
  localparam int CLS_W     = spq_pkg::CLS_W;
  localparam int WORD_W    = 2 * ID_WIDTH + 1 + VALUE_W;
  localparam int MEM_DEPTH = spq_pkg::NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // input register
  logic                 in_valid_r;
  logic                 in_func_r;
  logic [CLS_W-1:0]     in_cls_r;
  logic [ID_PORT_W-1:0] in_dev_r;
  logic                 in_has_r;
  logic [ID_PORT_W-1:0] in_sen_r;
  logic [VALUE_W-1:0]   in_value_r;

  // result register
  logic                 out_valid_r;
  spq_pkg::result_t     res_r;

  spq_pkg::result_t     res;
  spq_pkg::mem_ctl_t    mem_ctl;
  logic [ADDR_W-1:0]    mem_addr;
  logic [WORD_W-1:0]    wr_word;
  logic [WORD_W-1:0]    rd_word;
  logic [ID_WIDTH-1:0]  wr_dev;
  logic [ID_WIDTH-1:0]  wr_sen;
  logic                 adv;
  logic                 in_take;

  assign adv     = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_take = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_func_r  <= in_chan.func;
      in_cls_r   <= in_chan.priority_req;
      in_dev_r   <= in_chan.device_id;
      in_has_r   <= in_chan.has_sensor;
      in_sen_r   <= in_chan.sensor_id;
      in_value_r <= in_chan.event_value;
    end
  end

  spq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .func     (in_func_r),
    .cls_raw  (in_cls_r),
    .res      (res),
    .mem_ctl  (mem_ctl),
    .mem_addr (mem_addr)
  );

  // no sensor stores a zero sensor id
  assign wr_dev  = ID_WIDTH'(in_dev_r);
  assign wr_sen  = in_has_r ? ID_WIDTH'(in_sen_r) : '0;
  assign wr_word = {in_has_r, wr_sen, wr_dev, in_value_r};

  spq_mem #(
    .WIDTH  (WORD_W),
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_ctl.wr_en),
    .rd_en   (mem_ctl.rd_en),
    .addr    (mem_addr),
    .wr_data (wr_word),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  // served fields read as zero unless an event was dequeued
  assign out_chan.valid             = out_valid_r;
  assign out_chan.status            = res_r.status;
  assign out_chan.served_class      = res_r.served ? res_r.served_class : '0;
  assign out_chan.served_device     = res_r.served
                                      ? ID_PORT_W'(rd_word[VALUE_W +: ID_WIDTH]) : '0;
  assign out_chan.served_sensor     = res_r.served
                                      ? ID_PORT_W'(rd_word[VALUE_W + ID_WIDTH +: ID_WIDTH])
                                      : '0;
  assign out_chan.served_has_sensor = res_r.served && rd_word[WORD_W-1];
  assign out_chan.served_value      = res_r.served ? rd_word[VALUE_W-1:0] : '0;
  assign out_chan.level_high        = res_r.level_high;
  assign out_chan.level_medium      = res_r.level_medium;
  assign out_chan.level_low         = res_r.level_low;

`ifndef SYNTHESIS
  a_one_store_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.wr_en && mem_ctl.rd_en))
    else $error("store written and read for the same request");

  a_write_only_on_enq: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |-> (adv && in_func_r == spq_pkg::FUNC_ENQ))
    else $error("store write without an accepted enqueue");

  a_served_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.served == (res_r.status == spq_pkg::ST_DEQ)))
    else $error("served flag disagrees with status");

  a_held_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(in_func_r) && $stable(in_cls_r)))
    else $error("pending request lost while stalled");

  // read data is only meaningful for a dequeue result
  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(res_r)
                                          && (!res_r.served || $stable(rd_word))))
    else $error("stalled result changed");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-class strict priority event queue. A
// scoreboard keeps its own copy of the three queues, works out the status,
// served event and fill levels of every accepted request, and compares them
// field by field with the results, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD       = 10;
  localparam int QDEPTH       = 16;
  localparam int IDW          = 16;
  localparam int RANDOM_REQS  = 1000;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 100;
  localparam int DRAIN_CYCLES = 8;

  localparam int NUM_CLASSES  = spq_pkg::NUM_CLASSES;
  localparam int CLS_W        = spq_pkg::CLS_W;
  localparam int ID_PORT_W    = spq_pkg::ID_PORT_W;
  localparam int VALUE_W      = spq_pkg::VALUE_W;
  localparam int LVL_OUT_W    = spq_pkg::LVL_OUT_W;

  typedef struct packed {
    spq_pkg::status_t        status;
    logic [CLS_W-1:0]        cls;
    logic [ID_PORT_W-1:0]    device;
    logic                    has_sensor;
    logic [ID_PORT_W-1:0]    sensor;
    logic [VALUE_W-1:0]      value;
    logic [LVL_OUT_W-1:0]    level_high;
    logic [LVL_OUT_W-1:0]    level_medium;
    logic [LVL_OUT_W-1:0]    level_low;
  } queue_result_t;

  class event_scoreboard;
    logic [ID_PORT_W-1:0] dev_mem [NUM_CLASSES][QDEPTH];
    logic                 has_mem [NUM_CLASSES][QDEPTH];
    logic [ID_PORT_W-1:0] sen_mem [NUM_CLASSES][QDEPTH];
    logic [VALUE_W-1:0]   val_mem [NUM_CLASSES][QDEPTH];
    int unsigned          head [NUM_CLASSES];
    int unsigned          tail [NUM_CLASSES];
    int unsigned          fill [NUM_CLASSES];
    queue_result_t        expected [$];
    int                   errors;
    int                   requests;
    int                   status_seen [4];

    function new();
      foreach (fill[c]) begin
        head[c] = 0;
        tail[c] = 0;
        fill[c] = 0;
      end
      foreach (status_seen[s]) status_seen[s] = 0;
      errors   = 0;
      requests = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void note_request(logic func, logic [CLS_W-1:0] cls_in,
                               logic [ID_PORT_W-1:0] dev, logic has,
                               logic [ID_PORT_W-1:0] sen, logic [VALUE_W-1:0] value);
      queue_result_t    r;
      logic [CLS_W-1:0] cls;
      int unsigned      slot;
      bit               served;
      r = '0;
      // class three folds into low
      cls = (cls_in > spq_pkg::CLS_LOW) ? spq_pkg::CLS_LOW : cls_in;
      if (func == spq_pkg::FUNC_ENQ) begin
        if (fill[cls] >= QDEPTH) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          slot = tail[cls];
          dev_mem[cls][slot] = ID_PORT_W'(dev & ((1 << IDW) - 1));
          has_mem[cls][slot] = has;
          sen_mem[cls][slot] = has ? ID_PORT_W'(sen & ((1 << IDW) - 1)) : '0;
          val_mem[cls][slot] = value;
          tail[cls] = (slot + 1 >= QDEPTH) ? 0 : slot + 1;
          fill[cls]++;
          r.status = spq_pkg::ST_ENQ;
        end
      end else begin
        r.status = spq_pkg::ST_EMPTY;
        served = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (!served && fill[c] != 0) begin
            slot         = head[c];
            r.status     = spq_pkg::ST_DEQ;
            r.cls        = c[CLS_W-1:0];
            r.device     = dev_mem[c][slot];
            r.has_sensor = has_mem[c][slot];
            r.sensor     = sen_mem[c][slot];
            r.value      = val_mem[c][slot];
            fill[c]--;
            // an emptied queue restarts at slot zero
            if (fill[c] == 0) begin
              head[c] = 0;
              tail[c] = 0;
            end else begin
              head[c] = (slot + 1 >= QDEPTH) ? 0 : slot + 1;
            end
            served = 1'b1;
          end
        end
      end
      r.level_high   = LVL_OUT_W'(fill[0]);
      r.level_medium = LVL_OUT_W'(fill[1]);
      r.level_low    = LVL_OUT_W'(fill[2]);
      expected.push_back(r);
      requests++;
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (expected.size() == 0) begin
        $error("result with no request outstanding: status %0d", got.status);
        errors++;
        return;
      end
      want = expected.pop_front();
      status_seen[want.status]++;
      compare("status", want.status, got.status);
      compare("served_class", want.cls, got.cls);
      compare("served_device", want.device, got.device);
      compare("served_has_sensor", want.has_sensor, got.has_sensor);
      compare("served_sensor", want.sensor, got.sensor);
      compare("served_value", want.value, got.value);
      compare("level_high", want.level_high, got.level_high);
      compare("level_medium", want.level_medium, got.level_medium);
      compare("level_low", want.level_low, got.level_low);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  in_if ();
  spq_out_if out_if ();

  strict_priority_event_queue_core #(
    .QUEUE_DEPTH(QDEPTH),
    .ID_WIDTH   (IDW)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  event_scoreboard sb = new();

  bit quiet;
  bit rx_hold_req;
  int sent;

  always #(PERIOD / 2) clk = ~clk;

  // request and result monitors
  always @(posedge clk) begin : monitor
    queue_result_t seen;
    if (rst_n && in_if.valid && in_if.ready) begin
      sb.note_request(in_if.func, in_if.priority_req, in_if.device_id,
                      in_if.has_sensor, in_if.sensor_id, in_if.event_value);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.status       = spq_pkg::status_t'(out_if.status);
      seen.cls          = out_if.served_class;
      seen.device       = out_if.served_device;
      seen.has_sensor   = out_if.served_has_sensor;
      seen.sensor       = out_if.served_sensor;
      seen.value        = out_if.served_value;
      seen.level_high   = out_if.level_high;
      seen.level_medium = out_if.level_medium;
      seen.level_low    = out_if.level_low;
      sb.check_result(seen);
    end
  end

  // result receiver with random stalls and one long hold-off on request
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  // watchdog: too long without any request or result moving
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("strict_priority_event_queue_core test failed");
    $finish;
  end

  task automatic send_request(input logic func, input logic [CLS_W-1:0] cls,
                              input logic [ID_PORT_W-1:0] dev, input logic has,
                              input logic [ID_PORT_W-1:0] sen,
                              input logic [VALUE_W-1:0] value);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= func;
    in_if.priority_req <= cls;
    in_if.device_id    <= dev;
    in_if.has_sensor   <= has;
    in_if.sensor_id    <= sen;
    in_if.event_value  <= value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [ID_PORT_W-1:0] rand_id();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ID_PORT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // fixed_cls below zero picks any class code, three included
  task automatic send_random(input int enq_pct, input int fixed_cls);
    logic             func;
    logic [CLS_W-1:0] cls;
    logic [VALUE_W-1:0] value;
    func  = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ;
    cls   = (fixed_cls < 0) ? CLS_W'($urandom_range(0, 3)) : CLS_W'(fixed_cls);
    value = $urandom();
    if ($urandom_range(0, 9) == 0) value = $urandom_range(0, 1) ? '1 : '0;
    send_request(func, cls, rand_id(), 1'($urandom_range(0, 1)), rand_id(), value);
  endtask

  // step past the last accepting edge so its request is already noted
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    int cls_pick;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.func         <= spq_pkg::FUNC_ENQ;
    in_if.priority_req <= spq_pkg::CLS_HIGH;
    in_if.device_id    <= '0;
    in_if.has_sensor   <= 1'b0;
    in_if.sensor_id    <= '0;
    in_if.event_value  <= '0;
    quiet       = 1'b0;
    rx_hold_req = 1'b0;
    sent        = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dequeue on empty, then two events per class and priority order on the way out
    send_request(spq_pkg::FUNC_DEQ, spq_pkg::CLS_HIGH, 16'h0000, 1'b0, 16'h0000,
                 32'h0000_0000);
    send_request(spq_pkg::FUNC_ENQ, spq_pkg::CLS_LOW, 16'h1234, 1'b1, 16'h0000,
                 32'h8000_0001);
    send_request(spq_pkg::FUNC_ENQ, spq_pkg::CLS_MEDIUM, 16'hFFFF, 1'b1, 16'hFFFF,
                 32'hFFFF_FFFF);
    // no sensor: the sensor id given must come back as zero
    send_request(spq_pkg::FUNC_ENQ, spq_pkg::CLS_HIGH, 16'h0000, 1'b0, 16'hFFFF,
                 32'h0000_0000);
    // class code three lands in the low queue
    send_request(spq_pkg::FUNC_ENQ, 2'd3, 16'hA5A5, 1'b0, 16'h5A5A, 32'h7FFF_FFFF);
    send_request(spq_pkg::FUNC_ENQ, spq_pkg::CLS_HIGH, 16'h5555, 1'b1, 16'hAAAA,
                 32'hAAAA_AAAA);
    send_request(spq_pkg::FUNC_ENQ, spq_pkg::CLS_MEDIUM, 16'h8001, 1'b1, 16'h7FFE,
                 32'h5555_5555);
    repeat (8) send_request(spq_pkg::FUNC_DEQ, spq_pkg::CLS_LOW, 16'hFFFF, 1'b1, 16'hFFFF,
                            32'hFFFF_FFFF);
    // refill right after emptying checks the pointers restart
    send_request(spq_pkg::FUNC_ENQ, spq_pkg::CLS_LOW, 16'h0F0F, 1'b1, 16'hF0F0,
                 32'h0123_4567);
    send_request(spq_pkg::FUNC_DEQ, spq_pkg::CLS_HIGH, 16'h0000, 1'b0, 16'h0000,
                 32'h0000_0000);

    // back up the result side so the block stalls its input
    rx_hold_req = 1'b1;
    quiet = 1'b1;
    repeat (40) send_random(70, -1);
    quiet = 1'b0;
    in_if.valid <= 1'b0;
    wait_drained();

    target = sent + RANDOM_REQS;
    while (sent < target) begin
      quiet = ($urandom_range(0, 5) == 0);
      cls_pick = $urandom_range(0, 3);
      case ($urandom_range(0, 4))
        0: repeat (30) send_random(50, -1);
        1: repeat (25) send_random(85, -1);
        2: repeat (25) send_random(20, -1);
        3: begin
          // fill one class to full or past it, then dequeue a run that may pass empty
          repeat ($urandom_range(16, 20)) send_random(100, cls_pick);
          repeat ($urandom_range(10, 24)) send_random(0, -1);
        end
        default: repeat (30) send_random(60, cls_pick);
      endcase
    end
    quiet = 1'b0;
    in_if.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests: %0d enqueued, %0d dequeued,", sb.requests,
             sb.status_seen[spq_pkg::ST_ENQ], sb.status_seen[spq_pkg::ST_DEQ]);
    $display("  %0d refused on a full queue, %0d dequeues with all queues empty",
             sb.status_seen[spq_pkg::ST_FULL], sb.status_seen[spq_pkg::ST_EMPTY]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("strict_priority_event_queue_core test passed");
    end else begin
      $display("strict_priority_event_queue_core test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_in_if.sv
rtl/spq_out_if.sv
rtl/spq_mem.sv
rtl/spq_ctrl.sv
rtl/strict_priority_event_queue_core.sv
verif/tb_top.sv
